// ===== hdl/smn_pkg.sv =====
// Package for the noisy spectral mode update: shared constants, types and
// the Q16.16 multiply and saturate helpers. No dependencies.
`timescale 1ns / 1ps
package smn_pkg;

   // Q16.16 constants
   localparam logic signed [31:0] SQRT_TWO_Q = 32'sd92682;
   localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

   // CSR map, register index = paddr[4:2]
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_DRIFT_GAIN  = 3'd0;
   localparam logic [2:0] REG_STIFFNESS   = 3'd1;
   localparam logic [2:0] REG_NORM_SQ     = 3'd2;
   localparam logic [2:0] REG_NOISE_GAIN  = 3'd3;
   localparam logic [2:0] REG_SPACING_QX  = 3'd4;
   localparam logic [2:0] REG_SPACING_QY  = 3'd5;
   localparam logic [2:0] REG_SPACING_QZ  = 3'd6;
   localparam logic [2:0] REG_SLAB_OFFSET = 3'd7;

   // Pipeline geometry
   localparam int PIPE_DEPTH  = 19;
   localparam int SQRT_STAGES = 12;
   localparam int RAD_W       = 48;
   localparam int ROOT_W      = 24;
   localparam int REM_W       = 28;

   // Per-transaction payload carried down the main pipeline
   typedef struct packed {
      logic               func;
      logic signed [31:0] y_re;
      logic signed [31:0] y_im;
      logic signed [31:0] n_re;
      logic signed [31:0] n_im;
      logic signed [31:0] w_re;
      logic signed [31:0] w_im;
      logic signed [31:0] gain;
      logic signed [31:0] amp;
      logic signed [31:0] t;
      logic signed [31:0] v;
      logic signed [31:0] q2;
      logic signed [15:0] r_re;
      logic signed [15:0] r_im;
   } pipe_type;

   // Saturate a 33-bit sum to the Q16.16 range
   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x > 33'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (x < -33'sd2147483648)
         r = 32'sh80000000;
      else
         r = x[31:0];
      return r;
   endfunction

   // Q16.16 product: round half up, floor shift, saturate
   function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [47:0] s;
      logic signed [31:0] r;
      p = (64'(a) * 64'(b)) + ROUND_HALF;
      s = 48'(p >>> 16);
      if (s > 48'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (s < -48'sd2147483648)
         r = 32'sh80000000;
      else
         r = s[31:0];
      return r;
   endfunction

endpackage

// ===== hdl/smn_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
// Depends on smn_pkg for the radicand, root and stage sizes.
`timescale 1ns / 1ps
module smn_isqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [smn_pkg::RAD_W-1:0]    rad_in,
   output logic [smn_pkg::ROOT_W-1:0]   root_out
);
   import smn_pkg::*;

   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [RAD_W-1:0]  rad_ff  [SQRT_STAGES];
   logic [REM_W-1:0]  rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_in [SQRT_STAGES];
   logic [RAD_W-1:0]  rad_in_s[SQRT_STAGES];

   // Each stage retires two radicand bit pairs (restoring digit recurrence)
   always_comb begin
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            rem  = '0;
            root = '0;
            rad  = rad_in;
         end else begin
            rem  = rem_ff[j-1];
            root = root_ff[j-1];
            rad  = rad_ff[j-1];
         end
         for (int b = 0; b < 2; b++) begin
            rem   = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
            rad   = {rad[RAD_W-3:0], 2'b00};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[ROOT_W-2:0], 1'b1};
            end else begin
               root = {root[ROOT_W-2:0], 1'b0};
            end
         end
         rem_in[j]   = rem;
         root_in[j]  = root;
         rad_in_s[j] = rad;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < SQRT_STAGES; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            rad_ff[j]  <= rad_in_s[j];
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];

endmodule

// ===== hdl/spectral_mode_noisy_update.sv =====
// Top level of the noisy spectral Cahn-Hilliard mode update, Q16.16.
// Depends on smn_pkg and smn_isqrt.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  func, idx_z/y/x, field, nonlin, rand
//   rsp       out        rsp_valid / rsp_stall  new_re, new_im
//   csr       in/out     APB psel/penable       8 registers at 4*index
//
// One transaction per cycle enters while the output is not stalled; each result leaves
// through 19 register stages, 12 of them spanned by the pipelined square root.
// A stalled result at the output freezes the whole pipeline in place.
// Synchronous active-high reset clears valid bits and loads register defaults.
`timescale 1ns / 1ps
module spectral_mode_noisy_update #(
   parameter int GRID_Z = 64,
   parameter int GRID_Y = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smn_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [5:0]                        req_idx_z,
   input  logic [5:0]                        req_idx_y,
   input  logic [5:0]                        req_idx_x,
   input  logic signed [31:0]                req_field_re,
   input  logic signed [31:0]                req_field_im,
   input  logic signed [31:0]                req_nonlin_re,
   input  logic signed [31:0]                req_nonlin_im,
   input  logic signed [15:0]                req_rand_re,
   input  logic signed [15:0]                req_rand_im,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_new_re,
   output logic signed [31:0]                rsp_new_im
);
   import smn_pkg::*;

   localparam int ZW = $clog2(GRID_Z);
   localparam int YW = $clog2(GRID_Y);

   // ---------------- configuration registers ----------------
   logic signed [31:0] drift_gain_ff, stiffness_ff;
   logic [30:0]        norm_sq_ff, noise_gain_ff;
   logic [30:0]        spacing_qx_ff, spacing_qy_ff, spacing_qz_ff;
   logic [5:0]         slab_offset_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_gain_ff  <= '0;
         stiffness_ff   <= '0;
         norm_sq_ff     <= 31'd65536;
         noise_gain_ff  <= '0;
         spacing_qx_ff  <= 31'd65536;
         spacing_qy_ff  <= 31'd65536;
         spacing_qz_ff  <= 31'd65536;
         slab_offset_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DRIFT_GAIN:  drift_gain_ff  <= pwdata;
            REG_STIFFNESS:   stiffness_ff   <= pwdata;
            REG_NORM_SQ:     norm_sq_ff     <= pwdata[30:0];
            REG_NOISE_GAIN:  noise_gain_ff  <= pwdata[30:0];
            REG_SPACING_QX:  spacing_qx_ff  <= pwdata[30:0];
            REG_SPACING_QY:  spacing_qy_ff  <= pwdata[30:0];
            REG_SPACING_QZ:  spacing_qz_ff  <= pwdata[30:0];
            REG_SLAB_OFFSET: slab_offset_ff <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         REG_DRIFT_GAIN:  prdata = drift_gain_ff;
         REG_STIFFNESS:   prdata = stiffness_ff;
         REG_NORM_SQ:     prdata = {1'b0, norm_sq_ff};
         REG_NOISE_GAIN:  prdata = {1'b0, noise_gain_ff};
         REG_SPACING_QX:  prdata = {1'b0, spacing_qx_ff};
         REG_SPACING_QY:  prdata = {1'b0, spacing_qy_ff};
         REG_SPACING_QZ:  prdata = {1'b0, spacing_qz_ff};
         REG_SLAB_OFFSET: prdata = {26'd0, slab_offset_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic                  adv;
   logic [PIPE_DEPTH:1]   valid_ff;

   assign adv       = !(valid_ff[PIPE_DEPTH] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else if (adv)
         valid_ff <= {valid_ff[PIPE_DEPTH-1:1], req_valid};
   end

   // ---------------- index modulo tables ----------------
   logic [ZW-1:0] zmod_tab [128];
   logic [YW-1:0] ymod_tab [64];

   for (genvar i = 0; i < 128; i++) begin : g_zmod
      assign zmod_tab[i] = ZW'(i % GRID_Z);
   end
   for (genvar i = 0; i < 64; i++) begin : g_ymod
      assign ymod_tab[i] = YW'(i % GRID_Y);
   end

   // ---------------- side registers for the wavenumber front end ----------------
   logic [ZW-1:0]    fz_ff, fz_in;
   logic [YW-1:0]    fy_ff, fy_in;
   logic [5:0]       fx_ff;
   logic [30:0]      qx_ff, qy_ff, qz_ff, qx_in, qy_in, qz_in;
   logic signed [31:0] sx_ff, sy_ff, sz_ff;
   logic [6:0]       gz;
   logic [ZW-1:0]    mz;
   logic [YW-1:0]    my;

   // fold global z and y to wavenumber magnitudes
   always_comb begin
      gz = {1'b0, req_idx_z} + {1'b0, slab_offset_ff};
      mz = zmod_tab[gz];
      my = ymod_tab[req_idx_y];
      if ({1'b0, mz} > (ZW+1)'(GRID_Z / 2))
         fz_in = ZW'((ZW+1)'(GRID_Z) - {1'b0, mz});
      else
         fz_in = mz;
      if ({1'b0, my} > (YW+1)'(GRID_Y / 2))
         fy_in = YW'((YW+1)'(GRID_Y) - {1'b0, my});
      else
         fy_in = my;
   end

   // spacing times index (z and y folded), clipped at the positive limit
   always_comb begin
      logic [30+ZW:0] pz;
      logic [30+YW:0] py;
      logic [36:0]    px;
      pz = (31+ZW)'(spacing_qz_ff) * (31+ZW)'(fz_ff);
      py = (31+YW)'(spacing_qy_ff) * (31+YW)'(fy_ff);
      px = 37'(spacing_qx_ff) * 37'(fx_ff);
      qz_in = (pz > (31+ZW)'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : 31'(pz);
      qy_in = (py > (31+YW)'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : 31'(py);
      qx_in = (px > 37'h7FFFFFFF) ? 31'h7FFFFFFF : 31'(px);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fz_ff <= fz_in;
         fy_ff <= fy_in;
         fx_ff <= req_idx_x;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         sx_ff <= mulq($signed({1'b0, qx_ff}), $signed({1'b0, qx_ff}));
         sy_ff <= mulq($signed({1'b0, qy_ff}), $signed({1'b0, qy_ff}));
         sz_ff <= mulq($signed({1'b0, qz_ff}), $signed({1'b0, qz_ff}));
      end
   end

   // ---------------- main pipeline ----------------
   pipe_type          pipe_ff [1:PIPE_DEPTH];
   pipe_type          pipe_in [1:PIPE_DEPTH];
   logic [ROOT_W-1:0] root;
   logic signed [31:0] ng;

   assign ng = $signed({1'b0, noise_gain_ff});

   always_comb begin
      for (int k = 2; k <= PIPE_DEPTH; k++)
         pipe_in[k] = pipe_ff[k-1];

      // stage 1: capture, noise gain (sqrt 2 in real-plane mode)
      pipe_in[1]      = '0;
      pipe_in[1].func = req_func;
      pipe_in[1].y_re = req_field_re;
      pipe_in[1].y_im = req_field_im;
      pipe_in[1].n_re = req_nonlin_re;
      pipe_in[1].n_im = req_nonlin_im;
      pipe_in[1].r_re = req_rand_re;
      pipe_in[1].r_im = req_rand_im;
      pipe_in[1].gain = req_func ? mulq(ng, SQRT_TWO_Q) : ng;

      // stage 4: q squared (stages 2 and 3 live in the side registers)
      pipe_in[4].q2 = sat33(33'(sat33(33'(sx_ff) + 33'(sy_ff))) + 33'(sz_ff));

      // stage 5: t = G*q2, v = D*q2
      pipe_in[5].t = mulq(stiffness_ff, pipe_ff[4].q2);
      pipe_in[5].v = mulq(drift_gain_ff, pipe_ff[4].q2);

      // stage 6: t*y
      pipe_in[6].w_re = mulq(pipe_ff[5].t, pipe_ff[5].y_re);
      pipe_in[6].w_im = mulq(pipe_ff[5].t, pipe_ff[5].y_im);

      // stage 7: u = ynl + t*y
      pipe_in[7].w_re = sat33(33'(pipe_ff[6].n_re) + 33'(pipe_ff[6].w_re));
      pipe_in[7].w_im = sat33(33'(pipe_ff[6].n_im) + 33'(pipe_ff[6].w_im));

      // stage 8: v*u
      pipe_in[8].w_re = mulq(pipe_ff[7].v, pipe_ff[7].w_re);
      pipe_in[8].w_im = mulq(pipe_ff[7].v, pipe_ff[7].w_im);

      // stage 9: s = y - v*u
      pipe_in[9].w_re = sat33(33'(pipe_ff[8].y_re) - 33'(pipe_ff[8].w_re));
      pipe_in[9].w_im = sat33(33'(pipe_ff[8].y_im) - 33'(pipe_ff[8].w_im));

      // stage 10: z = s*N
      pipe_in[10].w_re = mulq(pipe_ff[9].w_re, $signed({1'b0, norm_sq_ff}));
      pipe_in[10].w_im = mulq(pipe_ff[9].w_im, $signed({1'b0, norm_sq_ff}));

      // stage 17: amplitude once the root is out of the sqrt pipe
      pipe_in[17].amp = mulq(pipe_ff[16].gain, $signed({8'd0, root}));

      // stage 18: noise per component, none on imaginary in real-plane mode
      pipe_in[18].n_re = mulq(pipe_ff[17].amp, 32'(pipe_ff[17].r_re));
      pipe_in[18].n_im = pipe_ff[17].func ? '0
                         : mulq(pipe_ff[17].amp, 32'(pipe_ff[17].r_im));

      // stage 19: new = z + noise
      pipe_in[19].w_re = sat33(33'(pipe_ff[18].w_re) + 33'(pipe_ff[18].n_re));
      pipe_in[19].w_im = sat33(33'(pipe_ff[18].w_im) + 33'(pipe_ff[18].n_im));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= PIPE_DEPTH; k++)
            pipe_ff[k] <= pipe_in[k];
      end
   end

   // square root of q2 in Q16.16: sqrt(q2 << 16), aligned with stage 16
   smn_isqrt u_isqrt (
      .clock    (clock),
      .en       (adv),
      .rad_in   ({pipe_ff[4].q2, 16'd0}),
      .root_out (root)
   );

   assign rsp_valid  = valid_ff[PIPE_DEPTH];
   assign rsp_new_re = pipe_ff[PIPE_DEPTH].w_re;
   assign rsp_new_im = pipe_ff[PIPE_DEPTH].w_im;

endmodule

// ===== hdl/smn_checker.sv =====
// Port-level checker for spectral_mode_noisy_update, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module smn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_new_re,
   input logic signed [31:0] rsp_new_im
);

   // result valid stays low right after reset while the pipeline refills
   a_reset_drain: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("result valid too soon after reset");

   // input backpressure only from a held result
   a_backpressure: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow the output stall");

   // a stalled result holds its transaction
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_re)
                                 && $stable(rsp_new_im))
      else $error("stalled result changed");

endmodule

bind spectral_mode_noisy_update smn_checker u_smn_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for spectral_mode_noisy_update: random and directed modes
// under several CSR settings, checked by a Q16.16 predictor held in a scoreboard.
// Depends on smn_pkg and the RTL of the block.
`timescale 1ns / 1ps

// One Fourier mode as offered on the request channel
typedef struct {
   bit               func;
   bit [5:0]         iz;
   bit [5:0]         iy;
   bit [5:0]         ix;
   bit signed [31:0] f_re;
   bit signed [31:0] f_im;
   bit signed [31:0] n_re;
   bit signed [31:0] n_im;
   bit signed [15:0] r_re;
   bit signed [15:0] r_im;
} mode_item_type;

typedef struct {
   bit signed [31:0] re;
   bit signed [31:0] im;
} mode_value_type;

class mode_scoreboard;
   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;
   localparam int NZ = 64;
   localparam int NY = 64;

   // register copies
   longint drift, stiff, norm, ngain, sx, sy, sz;
   int     slab;
   mode_value_type new_values[$];
   int     failures;
   int     checked;

   function new();
      drift = 0; stiff = 0; norm = 65536; ngain = 0;
      sx = 65536; sy = 65536; sz = 65536; slab = 0;
      failures = 0; checked = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         smn_pkg::REG_DRIFT_GAIN:  drift = longint'(signed'(val));
         smn_pkg::REG_STIFFNESS:   stiff = longint'(signed'(val));
         smn_pkg::REG_NORM_SQ:     norm  = longint'(val[30:0]);
         smn_pkg::REG_NOISE_GAIN:  ngain = longint'(val[30:0]);
         smn_pkg::REG_SPACING_QX:  sx    = longint'(val[30:0]);
         smn_pkg::REG_SPACING_QY:  sy    = longint'(val[30:0]);
         smn_pkg::REG_SPACING_QZ:  sz    = longint'(val[30:0]);
         smn_pkg::REG_SLAB_OFFSET: slab  = int'(val[5:0]);
         default: ;
      endcase
   endfunction

   function longint clip_q(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   // round half up, floor shift, saturate
   function longint qmul(longint a, longint b);
      longint t;
      t = a * b + 32768;
      return clip_q(t >>> 16);
   endfunction

   function longint int_root(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(r);
   endfunction

   function longint fold_idx(int idx, int n);
      idx = idx % n;
      if (idx > n / 2) return n - idx;
      return idx;
   endfunction

   // explicit Cahn-Hilliard step for one component, plus noise
   function longint ch_step(longint y, longint ynl, longint q2, longint noise);
      longint t, u, v, s, z;
      t = qmul(stiff, q2);
      u = clip_q(ynl + qmul(t, y));
      v = qmul(drift, q2);
      s = clip_q(y - qmul(v, u));
      z = qmul(s, norm);
      return clip_q(z + noise);
   endfunction

   function void note_mode(mode_item_type m);
      longint qx, qy, qz, q2, root, gain, amp, nre, nim;
      mode_value_type e;
      qz = clip_q(sz * fold_idx(int'(m.iz) + slab, NZ));
      qy = clip_q(sy * fold_idx(int'(m.iy), NY));
      qx = clip_q(sx * longint'(m.ix));
      q2 = clip_q(clip_q(qmul(qx, qx) + qmul(qy, qy)) + qmul(qz, qz));
      root = int_root(longint'(q2) << 16);
      gain = m.func ? qmul(ngain, 92682) : ngain;
      amp = qmul(gain, root);
      nre = qmul(amp, longint'(m.r_re));
      nim = m.func ? 0 : qmul(amp, longint'(m.r_im));
      e.re = 32'(ch_step(longint'(m.f_re), longint'(m.n_re), q2, nre));
      e.im = 32'(ch_step(longint'(m.f_im), longint'(m.n_im), q2, nim));
      new_values = {new_values, e};
   endfunction

   function void check_value(logic signed [31:0] re, logic signed [31:0] im);
      mode_value_type e;
      checked++;
      if (new_values.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: unexpected result re=%0d im=%0d", re, im);
         return;
      end
      e = new_values.pop_front();
      if (re !== e.re || im !== e.im) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: result %0d expected re=%0d im=%0d got re=%0d im=%0d",
                     checked, e.re, e.im, re, im);
      end
   endfunction

   function int pending();
      return new_values.size();
   endfunction
endclass

module tb;
   import smn_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic req_valid = 1'b0, req_stall;
   logic req_func = 1'b0;
   logic [5:0] req_idx_z = '0, req_idx_y = '0, req_idx_x = '0;
   logic signed [31:0] req_field_re = '0, req_field_im = '0;
   logic signed [31:0] req_nonlin_re = '0, req_nonlin_im = '0;
   logic signed [15:0] req_rand_re = '0, req_rand_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_new_re, rsp_new_im;

   mode_scoreboard sb = new();
   bit no_gaps = 0;
   bit hold_go = 0;
   int hold_left = 0;
   int wait_left = 0;
   int idle_cycles = 0;
   int sent = 0;

   spectral_mode_noisy_update dut (.*);

   always #5 clock = ~clock;

   // result side: check each transaction, stall at random or for a long hold
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_value(rsp_new_re, rsp_new_im);
            wait_left = no_gaps ? 0 : $urandom_range(0, 4);
         end
         if (hold_go) begin
            hold_go = 0;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // setup phase, then access phase, then idle with the bus released
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, val);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic load_regs(logic [31:0] d, logic [31:0] g, logic [31:0] n,
                            logic [31:0] ng, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic [31:0] off);
      write_reg(REG_DRIFT_GAIN, d);
      write_reg(REG_STIFFNESS, g);
      write_reg(REG_NORM_SQ, n);
      write_reg(REG_NOISE_GAIN, ng);
      write_reg(REG_SPACING_QX, x);
      write_reg(REG_SPACING_QY, y);
      write_reg(REG_SPACING_QZ, z);
      write_reg(REG_SLAB_OFFSET, off);
   endtask

   task automatic send_mode(mode_item_type m);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func <= m.func;
      req_idx_z <= m.iz;
      req_idx_y <= m.iy;
      req_idx_x <= m.ix;
      req_field_re <= m.f_re;
      req_field_im <= m.f_im;
      req_nonlin_re <= m.n_re;
      req_nonlin_im <= m.n_im;
      req_rand_re <= m.r_re;
      req_rand_im <= m.r_im;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_mode(m);
      sent++;
   endtask

   // mostly moderate values, sometimes full range
   function automatic bit signed [31:0] pick_q();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 2 ** 22)) - 32'sd2097152;
   endfunction

   function automatic mode_item_type random_mode();
      mode_item_type m;
      m.func = 1'($urandom_range(0, 1));
      m.iz = 6'($urandom_range(0, 63));
      m.iy = 6'($urandom_range(0, 63));
      m.ix = 6'($urandom_range(0, 32));
      m.f_re = pick_q();
      m.f_im = pick_q();
      m.n_re = pick_q();
      m.n_im = pick_q();
      m.r_re = 16'($urandom);
      m.r_im = 16'($urandom);
      return m;
   endfunction

   initial begin
      mode_item_type m;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: moderate physics-like setting
      load_regs(32'h0000_0800, 32'h0000_4000, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'd5);
      for (int k = 0; k < 20; k++) begin
         m = random_mode();
         m.func = k[0];
         case (k % 5)
            0: begin
               m.f_re = 32'sh7FFFFFFF; m.f_im = 32'sh80000000;
               m.n_re = 32'sh80000000; m.n_im = 32'sh7FFFFFFF;
            end
            1: begin
               m.iz = 6'd63; m.iy = 6'd63; m.ix = 6'd32;
               m.r_re = 16'sh7FFF; m.r_im = 16'sh8000;
            end
            2: begin
               m.iz = 6'd0; m.iy = 6'd0; m.ix = 6'd0;
               m.r_re = 16'sh8000; m.r_im = 16'sh7FFF;
            end
            3: begin
               // wrap of the global z index and fold at the Nyquist plane
               m.iz = 6'd59 + k[1:0]; m.iy = 6'd32; m.ix = 6'd31;
            end
            default: m.f_re = 32'sd0;
         endcase
         send_mode(m);
      end
      req_valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: load_regs(32'h0000_0100, 32'h0000_1000, 32'h0000_8000, 32'h0000_4000,
                         32'h0000_6000, 32'h0001_0000, 32'h0000_c000, 32'd0);
            1: load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd63);
            2: load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0,
                         32'd0, 32'd0, 32'd0, 32'd32);
            default: load_regs($urandom, $urandom, $urandom & 32'h7FFF_FFFF,
                               $urandom & 32'h7FFF_FFFF, $urandom_range(0, 32'h40000),
                               $urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
                               $urandom_range(0, 63));
         endcase
         no_gaps = (ph == 3);
         for (int k = 0; k < 86; k++) begin
            if (ph == 1 && k == 10) hold_go = 1;
            if (ph == 4 && k == 40) begin
               // sender waits for every result before going on
               req_valid <= 1'b0;
               while (sb.pending() != 0) @(posedge clock);
            end
            send_mode(random_mode());
         end
         req_valid <= 1'b0;
         no_gaps = 0;
         drain();
      end

      $display("Run covered %0d modes over 6 register settings, %0d results checked.",
               sent, sb.checked);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.failures, sb.pending());
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
